FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/pidsc_pkg.sv
package pidsc_pkg;

   // Gain and scale registers are signed Q8.8
   localparam int GAIN_W = 16;
   // Radix-4 Booth: two multiplier bits retired per step
   localparam int STEPS  = GAIN_W / 2;
   localparam int CNT_W  = $clog2(STEPS);

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_KP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 2'd3;

   // Reset values of the registers
   localparam logic signed [GAIN_W-1:0] KP_RESET    = 16'sd256;
   localparam logic signed [GAIN_W-1:0] KI_RESET    = 16'sd128;
   localparam logic signed [GAIN_W-1:0] KD_RESET    = 16'sd26;
   localparam logic signed [GAIN_W-1:0] SCALE_RESET = 16'sd256;

   // Status of one serial multiply unit
   typedef struct packed {
      logic busy;   // stepping through digits
      logic done;   // result held until taken
   } unit_ctl_type;

   // Decoded Booth digit: value is +-0, +-1 or +-2 times the multiplicand
   typedef struct packed {
      logic neg;
      logic one;
      logic two;
   } booth_sel_type;

   function automatic booth_sel_type booth_decode(input logic [2:0] bits);
      booth_sel_type sel;
      sel = '0;
      case (bits)
         3'b001, 3'b010: sel.one = 1'b1;
         3'b011:         sel.two = 1'b1;
         3'b100: begin
            sel.neg = 1'b1;
            sel.two = 1'b1;
         end
         3'b101, 3'b110: begin
            sel.neg = 1'b1;
            sel.one = 1'b1;
         end
         default: sel = '0;
      endcase
      return sel;
   endfunction

endpackage

FILE: src/pidsc_sum_unit.sv
// Three-term serial multiply-accumulate: kp*p + ki*i + kd*d.
// One Booth digit of each gain per cycle, partial sum shifted right by two,
// retired low bits collected in a shift register.
module pidsc_sum_unit #(
   parameter int XW = 19
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   take,
   input  logic signed [XW-1:0]                   op_p,
   input  logic signed [XW-1:0]                   op_i,
   input  logic signed [XW-1:0]                   op_d,
   input  logic signed [pidsc_pkg::GAIN_W-1:0]    gain_p,
   input  logic signed [pidsc_pkg::GAIN_W-1:0]    gain_i,
   input  logic signed [pidsc_pkg::GAIN_W-1:0]    gain_d,
   output pidsc_pkg::unit_ctl_type                ctl,
   output logic signed [XW+4+pidsc_pkg::GAIN_W-1:0] product
);

   localparam int GW = pidsc_pkg::GAIN_W;
   localparam int HW = XW + 4;
   localparam logic [pidsc_pkg::CNT_W-1:0] LAST = pidsc_pkg::CNT_W'(pidsc_pkg::STEPS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pidsc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [HW-1:0]          hi_ff, hi_in;
   logic [GW-1:0]                 lo_ff, lo_in;
   logic signed [XW-1:0]          xp_ff, xp_in, xi_ff, xi_in, xd_ff, xd_in;
   logic [GW:0]                   mp_ff, mp_in, mi_ff, mi_in, md_ff, md_in;
   logic signed [HW-1:0]          acc;

   // One Booth partial product, sign-extended to the accumulator width
   function automatic logic signed [HW-1:0] booth_term(input logic [2:0] bits,
                                                       input logic signed [XW-1:0] x);
      pidsc_pkg::booth_sel_type sel;
      logic signed [HW-1:0]     xe;
      logic signed [HW-1:0]     mag;
      sel = pidsc_pkg::booth_decode(bits);
      xe  = HW'(x);
      mag = sel.two ? (xe <<< 1) : (sel.one ? xe : '0);
      return sel.neg ? -mag : mag;
   endfunction

   // Add this cycle's three digit products
   always_comb begin
      acc = hi_ff + booth_term(mp_ff[2:0], xp_ff) + booth_term(mi_ff[2:0], xi_ff)
            + booth_term(md_ff[2:0], xd_ff);
   end

   // Load, step, hand off
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      xp_in   = xp_ff;
      xi_in   = xi_ff;
      xd_in   = xd_ff;
      mp_in   = mp_ff;
      mi_in   = mi_ff;
      md_in   = md_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = '0;
         xp_in   = op_p;
         xi_in   = op_i;
         xd_in   = op_d;
         mp_in   = {gain_p, 1'b0};
         mi_in   = {gain_i, 1'b0};
         md_in   = {gain_d, 1'b0};
      end else if (busy_ff) begin
         hi_in  = acc >>> 2;
         lo_in  = {acc[1:0], lo_ff[GW-1:2]};
         mp_in  = {2'b00, mp_ff[GW:2]};
         mi_in  = {2'b00, mi_ff[GW:2]};
         md_in  = {2'b00, md_ff[GW:2]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (take) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      xp_ff <= xp_in;
      xi_ff <= xi_in;
      xd_ff <= xd_in;
      mp_ff <= mp_in;
      mi_ff <= mi_in;
      md_ff <= md_in;
   end

   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign product  = {hi_ff, lo_ff};

endmodule

FILE: src/pidsc_scale_unit.sv
// Serial multiply of the controller sum by the output scale.
// One Booth digit per cycle; the bits shifted out are the fraction and are
// dropped, so the held value is floor(sum * scale / 2^16).
module pidsc_scale_unit #(
   parameter int XW = 39
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                take,
   input  logic signed [XW-1:0]                multiplicand,
   input  logic signed [pidsc_pkg::GAIN_W-1:0] scale,
   output pidsc_pkg::unit_ctl_type             ctl,
   output logic signed [XW+3:0]                product
);

   localparam int GW = pidsc_pkg::GAIN_W;
   localparam int HW = XW + 4;
   localparam logic [pidsc_pkg::CNT_W-1:0] LAST = pidsc_pkg::CNT_W'(pidsc_pkg::STEPS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pidsc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [HW-1:0]          hi_ff, hi_in;
   logic signed [XW-1:0]          x_ff, x_in;
   logic [GW:0]                   m_ff, m_in;
   logic signed [HW-1:0]          acc;

   function automatic logic signed [HW-1:0] booth_term(input logic [2:0] bits,
                                                       input logic signed [XW-1:0] x);
      pidsc_pkg::booth_sel_type sel;
      logic signed [HW-1:0]     xe;
      logic signed [HW-1:0]     mag;
      sel = pidsc_pkg::booth_decode(bits);
      xe  = HW'(x);
      mag = sel.two ? (xe <<< 1) : (sel.one ? xe : '0);
      return sel.neg ? -mag : mag;
   endfunction

   assign acc = hi_ff + booth_term(m_ff[2:0], x_ff);

   // Load, step, hand off
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         hi_in   = '0;
         x_in    = multiplicand;
         m_in    = {scale, 1'b0};
      end else if (busy_ff) begin
         hi_in  = acc >>> 2;
         m_in   = {2'b00, m_ff[GW:2]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (take) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      x_ff  <= x_in;
      m_ff  <= m_in;
   end

   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign product  = hi_ff;

endmodule

FILE: src/pid_speed_controller.sv
// An accepted request runs 8 Booth steps in the sum unit, then 8 in the scale unit,
// with a load and a handoff between them, before the output register raises rsp_tvalid.
// A new request is taken only once the 8-step sum unit is idle or hands its sum off;
// the scale unit works on the previous transaction meanwhile.
// Reset: synchronous, active high; gains return to their defaults, integral and
// previous error clear to zero, no response pending.
module pid_speed_controller #(
   parameter int SPEED_WIDTH    = 16,
   parameter int INTEGRAL_LIMIT = 1000,
   parameter int DUTY_MAX       = 1000
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // target_speed, measured_speed
   input  logic [((2*SPEED_WIDTH+7)/8)*8-1:0]              req_tdata,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // pwm_duty
   output logic [(($clog2(DUTY_MAX+1)+7)/8)*8-1:0]         rsp_tdata,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [pidsc_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  logic [pidsc_pkg::GAIN_W-1:0]                    csr_data
);

   localparam int GW     = pidsc_pkg::GAIN_W;
   localparam int SW     = SPEED_WIDTH;
   localparam int EW     = SW + 1;                              // error
   localparam int LIM_W  = $clog2(INTEGRAL_LIMIT + 1) + 1;      // clamped integral
   localparam int CW     = ((LIM_W > EW) ? LIM_W : EW) + 1;     // integral before clamp
   localparam int DW     = EW + 1;                              // derivative
   localparam int XW     = (DW > LIM_W) ? DW : LIM_W;           // sum unit operands
   localparam int SUM_W  = XW + 4 + GW;
   localparam int PW     = SUM_W + 4;
   localparam int DUTY_W = $clog2(DUTY_MAX + 1);
   localparam int OUT_W  = ((DUTY_W + 7) / 8) * 8;
   localparam logic signed [CW-1:0] LIM_POS = CW'(INTEGRAL_LIMIT);
   localparam logic signed [CW-1:0] LIM_NEG = -LIM_POS;

   logic signed [GW-1:0]      kp_ff, ki_ff, kd_ff, scale_ff;
   logic signed [LIM_W-1:0]   error_sum_ff;
   logic signed [EW-1:0]      last_error_ff;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]          rsp_tdata_ff;

   logic signed [SW-1:0]      target, measured;
   logic signed [EW-1:0]      err;
   logic signed [CW-1:0]      integ_raw, integ_clamp;
   logic signed [LIM_W-1:0]   integ;
   logic signed [DW-1:0]      deriv;
   logic                      req_accept;

   pidsc_pkg::unit_ctl_type   sum_ctl, scale_ctl;
   logic                      scale_start, out_load;
   logic signed [SUM_W-1:0]   sum;
   logic signed [PW-1:0]      scaled;
   logic [DUTY_W-1:0]         duty;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= pidsc_pkg::KP_RESET;
         ki_ff    <= pidsc_pkg::KI_RESET;
         kd_ff    <= pidsc_pkg::KD_RESET;
         scale_ff <= pidsc_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pidsc_pkg::REG_KP:    kp_ff    <= csr_data;
            pidsc_pkg::REG_KI:    ki_ff    <= csr_data;
            pidsc_pkg::REG_KD:    kd_ff    <= csr_data;
            pidsc_pkg::REG_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Error, clamped integral and derivative of the incoming transaction
   always_comb begin
      target    = req_tdata[SW-1:0];
      measured  = req_tdata[2*SW-1:SW];
      err       = EW'(target) - EW'(measured);
      integ_raw = CW'(error_sum_ff) + CW'(err);
      if (integ_raw > LIM_POS) begin
         integ_clamp = LIM_POS;
      end else if (integ_raw < LIM_NEG) begin
         integ_clamp = LIM_NEG;
      end else begin
         integ_clamp = integ_raw;
      end
      integ = integ_clamp[LIM_W-1:0];
      deriv = DW'(err) - DW'(last_error_ff);
   end

   assign req_tready = !sum_ctl.busy && (!sum_ctl.done || scale_start);
   assign req_accept = req_tvalid && req_tready;

   // Loop state advances as each request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (req_accept) begin
         error_sum_ff  <= integ;
         last_error_ff <= err;
      end
   end

   pidsc_sum_unit #(
      .XW (XW)
   ) u_sum (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .take    (scale_start),
      .op_p    (XW'(err)),
      .op_i    (XW'(integ)),
      .op_d    (XW'(deriv)),
      .gain_p  (kp_ff),
      .gain_i  (ki_ff),
      .gain_d  (kd_ff),
      .ctl     (sum_ctl),
      .product (sum)
   );

   // Sum moves to the scale unit once that unit is free
   assign scale_start = sum_ctl.done && !scale_ctl.busy && (!scale_ctl.done || out_load);

   pidsc_scale_unit #(
      .XW (SUM_W)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .start        (scale_start),
      .take         (out_load),
      .multiplicand (sum),
      .scale        (scale_ff),
      .ctl          (scale_ctl),
      .product      (scaled)
   );

   // Duty clamp: negative products give zero, products above DUTY_MAX give DUTY_MAX
   always_comb begin
      if (scaled[PW-1]) begin
         duty = '0;
      end else if (scaled > PW'(DUTY_MAX)) begin
         duty = DUTY_W'(DUTY_MAX);
      end else begin
         duty = scaled[DUTY_W-1:0];
      end
   end

   // Output register
   assign out_load = scale_ctl.done && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= OUT_W'(duty);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: src/pidsc_checker.sv
`include "assert_macros.svh"

// Port-level checks on the speed controller
module pidsc_checker #(
   parameter int DUTY_MAX = 1000
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_tvalid,
   input logic                                     req_tready,
   input logic                                     rsp_tvalid,
   input logic                                     rsp_tready,
   input logic [(($clog2(DUTY_MAX+1)+7)/8)*8-1:0]  rsp_tdata
);

   localparam int OUT_W = (($clog2(DUTY_MAX + 1) + 7) / 8) * 8;

   // A stalled response keeps its duty
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // Duty never leaves its clamp range
   `ASSERT_SAME(a_duty_range, rsp_tvalid, rsp_tdata <= OUT_W'(DUTY_MAX), "duty above limit")

   // Serial multiply keeps the request side closed after a transaction
   `ASSERT_NEXT(a_req_gap, req_tvalid && req_tready, !req_tready, "request taken on back-to-back cycles")

endmodule

bind pid_speed_controller pidsc_checker #(
   .DUTY_MAX (DUTY_MAX)
) u_pidsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
